// ----- src/ucfr_pkg.sv -----
// Shared types, constants and reply byte tables for the command frame responder.
package ucfr_pkg;

	localparam logic [7:0] HDR0       = 8'h10;
	localparam logic [7:0] HDR3       = 8'hC5;
	localparam logic [7:0] MARK_OK    = 8'hAA;
	localparam logic [7:0] CMD_MAC    = 8'h87;
	localparam logic [7:0] CMD_NAME   = 8'h81;
	localparam logic [7:0] CMD_MANU   = 8'h82;
	localparam logic [7:0] LEN_LIMIT  = 8'd40;
	localparam logic [7:0] LEN_MIN    = 8'd7;
	localparam logic [7:0] SUB_MAC    = 8'h07;
	localparam logic [7:0] SUB_NAME   = 8'h01;
	localparam logic [7:0] SUB_MANU   = 8'h02;
	localparam logic [7:0] ACK_STATUS = 8'h01;
	localparam logic [3:0] MAC_REPLY_LEN = 4'd14;
	localparam logic [3:0] ACK_REPLY_LEN = 4'd9;
	localparam logic [3:0] SUM_FIRST_IDX = 4'd4;

	// Reply kinds
	localparam logic [1:0] KIND_MAC      = 2'd0;
	localparam logic [1:0] KIND_ACK_NAME = 2'd1;
	localparam logic [1:0] KIND_ACK_MANU = 2'd2;

	typedef logic [1:0] kind_t;

	typedef struct packed {
		kind_t kind;
	} reply_req_t;

	function automatic logic [3:0] reply_len(input kind_t kind);
		logic [3:0] len;
		len = (kind == KIND_MAC) ? MAC_REPLY_LEN : ACK_REPLY_LEN;
		return len;
	endfunction

	// Byte idx of a reply; the final byte is the running checksum.
	function automatic logic [7:0] reply_byte(input kind_t kind, input logic [3:0] idx,
		input logic [47:0] mac, input logic [7:0] sum);
		logic [7:0] v;
		v = 8'h00;
		if (idx == reply_len(kind) - 4'd1) begin
			v = sum;
		end else begin
			unique case (idx)
				4'd0: v = HDR0;
				4'd1: v = 8'h00;
				4'd2: v = 8'h00;
				4'd3: v = HDR3;
				4'd4: v = {4'h0, reply_len(kind)};
				4'd5: v = MARK_OK;
				4'd6: begin
					unique case (kind)
						KIND_MAC:      v = SUB_MAC;
						KIND_ACK_NAME: v = SUB_NAME;
						KIND_ACK_MANU: v = SUB_MANU;
						default:       v = 8'h00;
					endcase
				end
				4'd7:    v = (kind == KIND_MAC) ? mac[47:40] : ACK_STATUS;
				4'd8:    v = mac[39:32];
				4'd9:    v = mac[31:24];
				4'd10:   v = mac[23:16];
				4'd11:   v = mac[15:8];
				4'd12:   v = mac[7:0];
				default: v = 8'h00;
			endcase
		end
		return v;
	endfunction

endpackage

// ----- src/ucfr_parser.sv -----
// Front end: hunts for frame headers, tracks the frame and classifies the reply.
module ucfr_parser import ucfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	output logic       req_valid,
	input  logic       req_ready,
	output reply_req_t req
);

	logic [7:0] byte_count_q;
	logic [7:0] frame_length_q;
	logic [7:0] marker_q;
	logic [7:0] command_q;

	logic       accept;
	logic [7:0] count_inc;
	logic [7:0] cmd;
	logic       frame_end;
	logic       want_reply;
	logic [7:0] count_next;

	assign s_tready  = req_ready;
	assign accept    = s_tvalid && s_tready;
	assign count_inc = byte_count_q + 8'd1;
	assign cmd       = (byte_count_q == 8'd6) ? s_tdata : command_q;
	assign frame_end = (byte_count_q >= 8'd6) && (count_inc >= frame_length_q);

	always_comb begin
		want_reply = 1'b0;
		req.kind   = KIND_MAC;
		if (frame_end && marker_q == MARK_OK) begin
			if (cmd == CMD_MAC) begin
				want_reply = 1'b1;
				req.kind   = KIND_MAC;
			end else if (cmd == CMD_NAME && frame_length_q < LEN_LIMIT) begin
				want_reply = 1'b1;
				req.kind   = KIND_ACK_NAME;
			end else if (cmd == CMD_MANU && frame_length_q < LEN_LIMIT) begin
				want_reply = 1'b1;
				req.kind   = KIND_ACK_MANU;
			end
		end
	end

	assign req_valid = accept && want_reply;

	// Resync on a stray header start byte
	always_comb begin
		priority if (byte_count_q == 8'd0) begin
			count_next = (s_tdata == HDR0) ? 8'd1 : 8'd0;
		end else if (byte_count_q == 8'd1 || byte_count_q == 8'd2) begin
			if (s_tdata == 8'h00)
				count_next = count_inc;
			else
				count_next = (s_tdata == HDR0) ? 8'd1 : 8'd0;
		end else if (byte_count_q == 8'd3) begin
			if (s_tdata == HDR3)
				count_next = 8'd4;
			else
				count_next = (s_tdata == HDR0) ? 8'd1 : 8'd0;
		end else if (byte_count_q == 8'd4) begin
			count_next = (s_tdata < LEN_MIN) ? 8'd0 : 8'd5;
		end else begin
			count_next = frame_end ? 8'd0 : count_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= 8'd0;
			frame_length_q <= 8'd0;
			marker_q       <= 8'd0;
			command_q      <= 8'd0;
		end else if (accept) begin
			byte_count_q <= count_next;
			if (byte_count_q == 8'd4)
				frame_length_q <= s_tdata;
			if (byte_count_q == 8'd5)
				marker_q <= s_tdata;
			if (byte_count_q == 8'd6)
				command_q <= s_tdata;
		end
	end

endmodule

// ----- src/ucfr_queue.sv -----
// Two-entry queue of reply requests between the parser and the emitter.
module ucfr_queue import ucfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  reply_req_t in_req,
	output logic       out_valid,
	input  logic       out_ready,
	output reply_req_t out_req
);

	reply_req_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_req   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// ----- src/ucfr_emitter.sv -----
// Back end: streams reply bytes with a running checksum into an output register.
module ucfr_emitter import ucfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  reply_req_t  req,
	input  logic [47:0] mac,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	logic       busy_q;
	kind_t      kind_q;
	logic [3:0] idx_q;
	logic [7:0] sum_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	logic       load;
	logic [7:0] next_byte;
	logic       next_last;

	assign req_ready = !busy_q;
	assign load      = busy_q && (!out_valid_q || m_tready);
	assign next_byte = reply_byte(kind_q, idx_q, mac, sum_q);
	assign next_last = (idx_q == reply_len(kind_q) - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q && req_valid)
				busy_q <= 1'b1;
			else if (load && next_last)
				busy_q <= 1'b0;
			if (load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req_valid) begin
			kind_q <= req.kind;
			idx_q  <= 4'd0;
			sum_q  <= 8'd0;
		end else if (load) begin
			idx_q <= idx_q + 4'd1;
			if (idx_q >= SUM_FIRST_IDX)
				sum_q <= sum_q + next_byte;
		end
		if (load) begin
			out_data_q <= next_byte;
			out_last_q <= next_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- src/uart_command_frame_responder.sv -----
// Top level of the command frame responder: parser, request queue and reply emitter.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+---------------------------------
//  s_       | in  | s_tvalid / s_tready         | s_tdata[7:0] = rx_byte
//  m_       | out | m_tvalid / m_tready         | m_tdata[7:0] = tx_byte, m_tlast = tx_last
//  cfg_     | in  | cfg_valid / cfg_ready       | cfg_data[47:0] = mac_address
//
// One received byte is taken per cycle while the request queue has room.
// A reply streams one byte per cycle from the emitter's output register while m_tready
// is high: 14 bytes for an address reply, 9 for an acknowledge.
// Reset clears the parser to header hunt, empties the queue and zeroes the address.
// Output stalls hold the emitter; the queue holds two pending replies before input stalls.
module uart_command_frame_responder import ucfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] tx_byte
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [47:0] cfg_data
);

	logic [47:0] mac_q;
	logic        push_valid;
	logic        push_ready;
	reply_req_t  push_req;
	logic        pop_valid;
	logic        pop_ready;
	reply_req_t  pop_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mac_q <= 48'd0;
		else if (cfg_valid && cfg_ready)
			mac_q <= cfg_data;
	end

	ucfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.req_valid (push_valid),
		.req_ready (push_ready),
		.req       (push_req)
	);

	ucfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_req    (push_req),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_req   (pop_req)
	);

	ucfr_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (pop_valid),
		.req_ready (pop_ready),
		.req       (pop_req),
		.mac       (mac_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- src/ucfr_checker.sv -----
// Port-level checks for the command frame responder, bound to the top level.
module ucfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// Hold a stalled transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output transaction changed");

	assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	// A reply streams without gaps once started
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a reply");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata == 8'h10)
		else $error("reply does not open with the header byte");

endmodule

bind uart_command_frame_responder ucfr_checker u_ucfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
